[hdl/rounded_eye_span_rasterizer_top_defines.svh]
// Assertion macros shared by the rasterizer RTL.
`ifndef ROUNDED_EYE_SPAN_RASTERIZER_TOP_DEFINES_SVH
`define ROUNDED_EYE_SPAN_RASTERIZER_TOP_DEFINES_SVH

// same-cycle implication, muted during reset
`define RESR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, muted during reset
`define RESR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[hdl/resr_pkg.sv]
// Shared types and constants of the rounded eye span rasterizer.
`default_nettype none
package resr_pkg;

   localparam int EYE_HEIGHT_CAP = 32;
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_W        = $clog2(Q_DEPTH);
   localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);
   localparam int NUM_W          = 18;   // margin numerator, amp * (H^2 - sq)
   localparam int QUO_W          = 6;    // margin quotient, below 64

   // classified eye, handed from front to back
   typedef struct packed {
      logic               empty;   // H <= 0: one undrawn last word
      logic [5:0]         rows;    // H, 1..63
      logic signed [12:0] top;     // display row of row 0
      logic signed [12:0] cxa;     // centre column plus shift
      logic [5:0]         hw;      // half width
      logic [5:0]         rt;
      logic [5:0]         rb;
   } eye_desc_type;

endpackage
`default_nettype wire

[hdl/rounded_eye_span_rasterizer_top.sv]
// Top level of the rounded eye span rasterizer: front, queue, back.
// Path: queue, back-end IDLE, SQR, MUL, DIV, EMIT; an empty eye goes from IDLE to EMIT.
// Rows go one at a time through the back end's shared squarer, multiplier and
//   6-step restoring divider; a new eye is popped only after the current eye's last row.
// The front and a 2-deep queue accept up to two more eyes while the back end works.
// Reset: synchronous, active high; clears the queue, back-end FSM and output valid,
//   and sets fill_color to 0xFFFF.
`default_nettype none
module rounded_eye_span_rasterizer_top
   import resr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data,
   // eye words
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [10:0]        req_mid_x,
   input  wire logic [10:0]        req_mid_y,
   input  wire logic signed [7:0]  req_shift_x,
   input  wire logic signed [7:0]  req_shift_y,
   input  wire logic [5:0]         req_eye_height,
   input  wire logic [6:0]         req_eye_width,
   input  wire logic signed [8:0]  req_top_tilt,
   input  wire logic signed [8:0]  req_bottom_tilt,
   input  wire logic [5:0]         req_top_round,
   input  wire logic [5:0]         req_bottom_round,
   // span words
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [12:0]      rsp_row,
   output logic signed [12:0]      rsp_span_start,
   output logic [7:0]              rsp_span_length,
   output logic                    rsp_span_drawn,
   output logic                    rsp_last_row
);

   // Span color register. No output port or span word field carries it.
   logic [15:0] fill_color_ff, fill_color_in;

   assign fill_color_in = csr_wr_en ? csr_wr_data : fill_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_color_ff <= 16'hFFFF;
      end else begin
         fill_color_ff <= fill_color_in;
      end
   end

   // front -> queue
   logic         push_valid;
   logic         push_ready;
   eye_desc_type push_desc;
   // queue -> back
   logic         pop_valid;
   logic         pop_ready;
   eye_desc_type pop_desc;

   // Front: saturates the height, applies both tilts (truncating /512),
   // flags empty eyes and works out the top row and centre column.
   resr_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mid_x        (req_mid_x),
      .req_mid_y        (req_mid_y),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .req_eye_height   (req_eye_height),
      .req_eye_width    (req_eye_width),
      .req_top_tilt     (req_top_tilt),
      .req_bottom_tilt  (req_bottom_tilt),
      .req_top_round    (req_top_round),
      .req_bottom_round (req_bottom_round),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_desc        (push_desc)
   );

   // Queue decouples the front from the per-row back end.
   resr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   // Back: per row, square -> scale by round amplitude -> divide by H^2,
   // then trim both ends by the margin and register the span word.
   resr_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_desc        (pop_desc),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row         (rsp_row),
      .rsp_span_start  (rsp_span_start),
      .rsp_span_length (rsp_span_length),
      .rsp_span_drawn  (rsp_span_drawn),
      .rsp_last_row    (rsp_last_row)
   );

endmodule
`default_nettype wire

[hdl/resr_front.sv]
// Front end: takes an eye word, works out its height and placement.
`default_nettype none
module resr_front
   import resr_pkg::*;
(
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [10:0]        req_mid_x,
   input  wire logic [10:0]        req_mid_y,
   input  wire logic signed [7:0]  req_shift_x,
   input  wire logic signed [7:0]  req_shift_y,
   input  wire logic [5:0]         req_eye_height,
   input  wire logic [6:0]         req_eye_width,
   input  wire logic signed [8:0]  req_top_tilt,
   input  wire logic signed [8:0]  req_bottom_tilt,
   input  wire logic [5:0]         req_top_round,
   input  wire logic [5:0]         req_bottom_round,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output eye_desc_type            push_desc
);

   // divide by 512, rounding toward zero; |result| <= 16
   function automatic logic signed [6:0] trunc512(input logic signed [15:0] p);
      logic signed [15:0] adj;
      adj = p[15] ? (p + 16'sd511) : p;
      return 7'(adj >>> 9);
   endfunction

   logic [5:0]         h_sat;
   logic signed [15:0] prod_t;
   logic signed [15:0] prod_b;
   logic signed [6:0]  tq_t;
   logic signed [6:0]  tq_b;
   logic signed [7:0]  h_tot;
   logic [5:0]         rows;

   always_comb begin
      h_sat  = (req_eye_height > 6'(EYE_HEIGHT_CAP)) ? 6'(EYE_HEIGHT_CAP) : req_eye_height;
      prod_t = $signed({1'b0, h_sat}) * req_top_tilt;
      prod_b = $signed({1'b0, h_sat}) * req_bottom_tilt;
      tq_t   = trunc512(prod_t);
      tq_b   = trunc512(prod_b);
      h_tot  = $signed({2'b00, h_sat}) + 8'(tq_t) - 8'(tq_b);
      rows   = h_tot[5:0];

      push_desc.empty = h_tot[7] || (h_tot == 8'sd0);
      push_desc.rows  = rows;
      push_desc.top   = $signed({2'b00, req_mid_y}) - $signed({8'b0, rows[5:1]})
                        + 13'(req_shift_y);
      push_desc.cxa   = $signed({2'b00, req_mid_x}) + 13'(req_shift_x);
      push_desc.hw    = req_eye_width[6:1];
      push_desc.rt    = req_top_round;
      push_desc.rb    = req_bottom_round;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

endmodule
`default_nettype wire

[hdl/resr_queue.sv]
// Short FIFO of classified eyes between front and back.
`default_nettype none
`include "rounded_eye_span_rasterizer_top_defines.svh"
module resr_queue
   import resr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire eye_desc_type push_desc,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output eye_desc_type      pop_desc
);

   eye_desc_type       mem_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
      return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   `RESR_ASSERT_NOW(a_q_count_bound, clock, reset, 1'b1, count_ff <= Q_CNT_W'(Q_DEPTH))
   `RESR_ASSERT_NOW(a_q_no_pop_empty, clock, reset, count_ff == '0, !pop)
   `RESR_ASSERT_NEXT(a_q_ptr_gap, clock, reset, count_ff == '0, wr_ptr_ff == rd_ptr_ff || count_ff != '0 || $past(push))

endmodule
`default_nettype wire

[hdl/resr_back.sv]
// Back end: walks the rows of one eye, computes margins, emits span words.
`default_nettype none
`include "rounded_eye_span_rasterizer_top_defines.svh"
module resr_back
   import resr_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               pop_valid,
   output logic                    pop_ready,
   input  wire eye_desc_type       pop_desc,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [12:0]      rsp_row,
   output logic signed [12:0]      rsp_span_start,
   output logic [7:0]              rsp_span_length,
   output logic                    rsp_span_drawn,
   output logic                    rsp_last_row
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQR  = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   eye_desc_type       desc_ff, desc_in;
   logic [11:0]        h2_ff, h2_in;
   logic [5:0]         row_ff, row_in;
   logic [11:0]        diff_ff, diff_in;
   logic [5:0]         amp_ff, amp_in;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic [2:0]         bit_ff, bit_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [12:0] rsp_row_ff, rsp_row_in;
   logic signed [12:0] rsp_start_ff, rsp_start_in;
   logic [7:0]         rsp_len_ff, rsp_len_in;
   logic               rsp_drawn_ff, rsp_drawn_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               upper;
   logic [6:0]         sq_op;
   logic [13:0]        sq;
   logic [NUM_W-1:0]   div_cmp;
   logic signed [12:0] left;
   logic signed [12:0] right;
   logic               is_last;
   logic               emit;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign emit = (state_ff == ST_EMIT) && out_free;
   assign is_last = desc_ff.empty || (row_ff == desc_ff.rows - 1'b1);

   always_comb begin
      upper   = ({row_ff, 1'b0} < {1'b0, desc_ff.rows});
      sq_op   = upper ? {row_ff, 1'b0} : ({desc_ff.rows, 1'b0} - {row_ff, 1'b0});
      sq      = sq_op * sq_op;
      div_cmp = {6'b0, h2_ff} << bit_ff;
      left    = desc_ff.cxa - $signed({7'b0, desc_ff.hw}) + $signed({7'b0, quo_ff});
      right   = desc_ff.cxa + $signed({7'b0, desc_ff.hw}) - $signed({7'b0, quo_ff});
   end

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      h2_in        = h2_ff;
      row_in       = row_ff;
      diff_in      = diff_ff;
      amp_in       = amp_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_row_in   = rsp_row_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_drawn_in = rsp_drawn_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               desc_in  = pop_desc;
               h2_in    = pop_desc.rows * pop_desc.rows;
               row_in   = '0;
               quo_in   = '0;
               state_in = pop_desc.empty ? ST_EMIT : ST_SQR;
            end
         end
         ST_SQR: begin
            diff_in  = h2_ff - sq[11:0];
            amp_in   = upper ? desc_ff.rt : desc_ff.rb;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            rem_in   = amp_ff * diff_ff;
            quo_in   = '0;
            bit_in   = 3'(QUO_W - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (rem_ff >= div_cmp) begin
               rem_in         = rem_ff - div_cmp;
               quo_in[bit_ff] = 1'b1;
            end
            if (bit_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = is_last;
               if (desc_ff.empty) begin
                  rsp_row_in   = '0;
                  rsp_start_in = '0;
                  rsp_len_in   = '0;
                  rsp_drawn_in = 1'b0;
               end else begin
                  rsp_row_in   = desc_ff.top + $signed({7'b0, row_ff});
                  rsp_start_in = left;
                  rsp_drawn_in = (left < right);
                  rsp_len_in   = (left < right) ? 8'(right - left + 13'sd1) : 8'd0;
               end
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  row_in   = row_ff + 1'b1;
                  state_in = ST_SQR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff      <= desc_in;
      h2_ff        <= h2_in;
      row_ff       <= row_in;
      diff_ff      <= diff_in;
      amp_ff       <= amp_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      bit_ff       <= bit_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_drawn_ff <= rsp_drawn_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_span_start  = rsp_start_ff;
   assign rsp_span_length = rsp_len_ff;
   assign rsp_span_drawn  = rsp_drawn_ff;
   assign rsp_last_row    = rsp_last_ff;

   // partial remainder must stay below divisor << (bit + 1) or the quotient overflows
   `RESR_ASSERT_NOW(a_div_rem_bound, clock, reset, state_ff == ST_DIV, ({1'b0, rem_ff} < ({7'b0, h2_ff} << (bit_ff + 3'd1))))
   `RESR_ASSERT_NEXT(a_last_to_idle, clock, reset, emit && is_last, state_ff == ST_IDLE)
   `RESR_ASSERT_NOW(a_row_in_range, clock, reset, state_ff == ST_EMIT && !desc_ff.empty, row_ff < desc_ff.rows)

endmodule
`default_nettype wire

[bench/resr_span_checker.sv]
`timescale 1ns / 1ps
// Span checker: predicts the span words of each accepted eye word and compares them.
module resr_span_checker
   import resr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [10:0]        req_mid_x,
   input  logic [10:0]        req_mid_y,
   input  logic signed [7:0]  req_shift_x,
   input  logic signed [7:0]  req_shift_y,
   input  logic [5:0]         req_eye_height,
   input  logic [6:0]         req_eye_width,
   input  logic signed [8:0]  req_top_tilt,
   input  logic signed [8:0]  req_bottom_tilt,
   input  logic [5:0]         req_top_round,
   input  logic [5:0]         req_bottom_round,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [12:0] rsp_row,
   input  logic signed [12:0] rsp_span_start,
   input  logic [7:0]         rsp_span_length,
   input  logic               rsp_span_drawn,
   input  logic               rsp_last_row,
   output int                 fail_count,
   output int                 pending,
   output int                 eyes_seen,
   output int                 empty_seen,
   output int                 spans_seen,
   output int                 drawn_seen,
   output int                 color_writes
);

   localparam int ROW_CAP = 64;

   typedef struct packed {
      logic signed [12:0] row;
      logic signed [12:0] start;
      logic [7:0]         length;
      logic               drawn;
      logic               last;
   } span_word_type;

   span_word_type due_spans[$];
   logic [15:0]   fill_shadow;   // tracked only; never shows up in a span word

   function automatic void predict_spans(
      input logic [10:0]        cx,
      input logic [10:0]        cy,
      input logic signed [7:0]  sx,
      input logic signed [7:0]  sy,
      input logic [5:0]         height,
      input logic [6:0]         width,
      input logic signed [8:0]  tilt_t,
      input logic signed [8:0]  tilt_b,
      input logic [5:0]         round_t,
      input logic [5:0]         round_b
   );
      int h, rows, rows_sq, hw, top, cxa, m, lft, rgt, d;
      span_word_type w;
      h = int'(height);
      if (h > EYE_HEIGHT_CAP)
         h = EYE_HEIGHT_CAP;
      // SV integer division truncates toward zero
      rows = h + (h * int'(tilt_t)) / 512 - (h * int'(tilt_b)) / 512;
      if (rows <= 0) begin
         w = '0;
         w.last = 1'b1;
         due_spans.push_back(w);
         empty_seen++;
         return;
      end
      if (rows > ROW_CAP)
         rows = ROW_CAP;
      rows_sq = rows * rows;
      hw      = int'(width) / 2;
      top     = int'(cy) - rows / 2 + int'(sy);
      cxa     = int'(cx) + int'(sx);
      for (int r = 0; r < rows; r++) begin
         if (2 * r < rows) begin
            m = (int'(round_t) * (rows_sq - 4 * r * r)) / rows_sq;
         end else begin
            d = 2 * rows - 2 * r;
            m = (int'(round_b) * (rows_sq - d * d)) / rows_sq;
         end
         lft     = cxa - hw + m;
         rgt     = cxa + hw - m;
         w.row   = 13'(top + r);
         w.start = 13'(lft);
         w.drawn = (lft < rgt);
         w.length = w.drawn ? 8'(rgt - lft + 1) : 8'd0;
         w.last  = (r == rows - 1);
         due_spans.push_back(w);
      end
   endfunction

   always @(posedge clock) begin : watch
      span_word_type due;
      if (reset) begin
         due_spans.delete();
         fill_shadow  = 16'hFFFF;
         fail_count   = 0;
         eyes_seen    = 0;
         empty_seen   = 0;
         spans_seen   = 0;
         drawn_seen   = 0;
         color_writes = 0;
      end else begin
         if (csr_wr_en) begin
            fill_shadow = csr_wr_data;
            color_writes++;
         end
         // pop before push so a stray word is never matched to a fresh eye
         if (rsp_valid && rsp_ready) begin
            spans_seen++;
            if (rsp_span_drawn)
               drawn_seen++;
            if (due_spans.size() == 0) begin
               $error("span word with nothing expected: row %0d start %0d",
                      rsp_row, rsp_span_start);
               fail_count++;
            end else begin
               due = due_spans.pop_front();
               if (rsp_row !== due.row) begin
                  $error("row: expected %0d, got %0d", due.row, rsp_row);
                  fail_count++;
               end
               if (rsp_span_start !== due.start) begin
                  $error("span_start: expected %0d, got %0d", due.start, rsp_span_start);
                  fail_count++;
               end
               if (rsp_span_length !== due.length) begin
                  $error("span_length: expected %0d, got %0d", due.length, rsp_span_length);
                  fail_count++;
               end
               if (rsp_span_drawn !== due.drawn) begin
                  $error("span_drawn: expected %0d, got %0d", due.drawn, rsp_span_drawn);
                  fail_count++;
               end
               if (rsp_last_row !== due.last) begin
                  $error("last_row: expected %0d, got %0d", due.last, rsp_last_row);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            eyes_seen++;
            predict_spans(req_mid_x, req_mid_y, req_shift_x, req_shift_y, req_eye_height,
                          req_eye_width, req_top_tilt, req_bottom_tilt, req_top_round,
                          req_bottom_round);
         end
      end
      pending = due_spans.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top: drives eye words and fill_color writes, stalls the span side, gives the verdict.
module tb_top;

   localparam int HOLD_CYCLES = 400;    // long span-side hold-off that backs up the input
   localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
   localparam int TAIL_CYCLES = 16;     // settle time after the last span word

   typedef struct packed {
      logic [10:0]       mid_x;
      logic [10:0]       mid_y;
      logic signed [7:0] shift_x;
      logic signed [7:0] shift_y;
      logic [5:0]        height;
      logic [6:0]        width;
      logic signed [8:0] tilt_t;
      logic signed [8:0] tilt_b;
      logic [5:0]        round_t;
      logic [5:0]        round_b;
   } eye_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // all block inputs start at known values
   logic               csr_wr_en        = 1'b0;
   logic [15:0]        csr_wr_data      = '0;
   logic               req_valid        = 1'b0;
   logic [10:0]        req_mid_x        = '0;
   logic [10:0]        req_mid_y        = '0;
   logic signed [7:0]  req_shift_x      = '0;
   logic signed [7:0]  req_shift_y      = '0;
   logic [5:0]         req_eye_height   = '0;
   logic [6:0]         req_eye_width    = '0;
   logic signed [8:0]  req_top_tilt     = '0;
   logic signed [8:0]  req_bottom_tilt  = '0;
   logic [5:0]         req_top_round    = '0;
   logic [5:0]         req_bottom_round = '0;
   logic               rsp_ready        = 1'b0;

   logic               req_ready;
   logic               rsp_valid;
   logic signed [12:0] rsp_row;
   logic signed [12:0] rsp_span_start;
   logic [7:0]         rsp_span_length;
   logic               rsp_span_drawn;
   logic               rsp_last_row;

   int fail_count, pending, eyes_seen, empty_seen, spans_seen, drawn_seen, color_writes;
   int quiet_cycles = 0;

   logic         squeeze_req = 1'b0;   // asks the span side for one long hold-off
   eye_word_type eye_plan[$];          // eye words of the current phase, in send order

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rounded_eye_span_rasterizer_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mid_x        (req_mid_x),
      .req_mid_y        (req_mid_y),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .req_eye_height   (req_eye_height),
      .req_eye_width    (req_eye_width),
      .req_top_tilt     (req_top_tilt),
      .req_bottom_tilt  (req_bottom_tilt),
      .req_top_round    (req_top_round),
      .req_bottom_round (req_bottom_round),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row          (rsp_row),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_drawn   (rsp_span_drawn),
      .rsp_last_row     (rsp_last_row)
   );

   resr_span_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mid_x        (req_mid_x),
      .req_mid_y        (req_mid_y),
      .req_shift_x      (req_shift_x),
      .req_shift_y      (req_shift_y),
      .req_eye_height   (req_eye_height),
      .req_eye_width    (req_eye_width),
      .req_top_tilt     (req_top_tilt),
      .req_bottom_tilt  (req_bottom_tilt),
      .req_top_round    (req_top_round),
      .req_bottom_round (req_bottom_round),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_row          (rsp_row),
      .rsp_span_start   (rsp_span_start),
      .rsp_span_length  (rsp_span_length),
      .rsp_span_drawn   (rsp_span_drawn),
      .rsp_last_row     (rsp_last_row),
      .fail_count       (fail_count),
      .pending          (pending),
      .eyes_seen        (eyes_seen),
      .empty_seen       (empty_seen),
      .spans_seen       (spans_seen),
      .drawn_seen       (drawn_seen),
      .color_writes     (color_writes)
   );

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(negedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no word moved for %0d cycles, %0d span words outstanding",
                  quiet_cycles, pending);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Span side: ready follows a probability that changes between random-length windows,
   // from always-ready down to mostly stalled. One long hold-off on request.
   initial begin : rsp_side
      int window, pct;
      window = 0;
      pct    = 100;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            rsp_ready <= 1'b0;
            for (int n = 1; n < HOLD_CYCLES; n++)
               @(negedge clock);
         end else begin
            if (window == 0) begin
               window = $urandom_range(20, 80);
               case ($urandom_range(3))
                  0: pct = 100;
                  1: pct = 75;
                  2: pct = 40;
                  default: pct = 12;
               endcase
            end
            window--;
            rsp_ready <= ($urandom_range(99) < pct);
         end
      end
   end

   function automatic eye_word_type mk_eye(int mx, int my, int sx, int sy, int h, int w,
                                           int tt, int tb, int rt, int rb);
      eye_word_type e;
      e.mid_x   = 11'(mx);
      e.mid_y   = 11'(my);
      e.shift_x = 8'(sx);
      e.shift_y = 8'(sy);
      e.height  = 6'(h);
      e.width   = 7'(w);
      e.tilt_t  = 9'(tt);
      e.tilt_b  = 9'(tb);
      e.round_t = 6'(rt);
      e.round_b = 6'(rb);
      return e;
   endfunction

   // Mostly short eyes to keep the run quick, a few tall and oversized ones,
   // and the occasional zero height for the empty case.
   function automatic eye_word_type random_eye();
      eye_word_type e;
      int pick;
      e.mid_x   = 11'($urandom_range(0, 2047));
      e.mid_y   = 11'($urandom_range(0, 2047));
      e.shift_x = 8'($urandom_range(0, 255));
      e.shift_y = 8'($urandom_range(0, 255));
      e.tilt_t  = 9'($urandom_range(0, 511));
      e.tilt_b  = 9'($urandom_range(0, 511));
      e.round_t = 6'($urandom_range(0, 63));
      e.round_b = 6'($urandom_range(0, 63));
      pick = $urandom_range(99);
      if (pick < 6)
         e.height = 6'd0;
      else if (pick < 14)
         e.height = 6'($urandom_range(33, 63));
      else if (pick < 30)
         e.height = 6'($urandom_range(17, 32));
      else
         e.height = 6'($urandom_range(1, 16));
      pick = $urandom_range(99);
      e.width = (pick < 15) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
      return e;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic offer_eye(input eye_word_type e);
      req_valid        <= 1'b1;
      req_mid_x        <= e.mid_x;
      req_mid_y        <= e.mid_y;
      req_shift_x      <= e.shift_x;
      req_shift_y      <= e.shift_y;
      req_eye_height   <= e.height;
      req_eye_width    <= e.width;
      req_top_tilt     <= e.tilt_t;
      req_bottom_tilt  <= e.tilt_b;
      req_top_round    <= e.round_t;
      req_bottom_round <= e.round_b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Sends the planned eye words in bursts; gapless keeps valid up throughout.
   task automatic send_plan(input bit gapless);
      int burst, gap;
      burst = $urandom_range(1, 8);
      while (eye_plan.size() != 0) begin
         offer_eye(eye_plan.pop_front());
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 10);
            gap   = gapless ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic plan_random(input int count);
      repeat (count) eye_plan.push_back(random_eye());
   endtask

   // The block is idle once every expected span word has come back.
   task automatic drain();
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_fill(input logic [15:0] color);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= color;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin : stimulus
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: fill_color at zero
      write_fill(16'h0000);
      // zero height: empty eye
      eye_plan.push_back(mk_eye(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // oversized height with extreme tilts: tallest eye, 63 rows, all other fields at max
      eye_plan.push_back(mk_eye(2047, 2047, 127, 127, 63, 127, 255, -256, 63, 63));
      // tilts pull the height down to a single row
      eye_plan.push_back(mk_eye(1024, 1024, 0, 0, 32, 127, -256, 255, 5, 5));
      // negative row and column, zero width: undrawn row
      eye_plan.push_back(mk_eye(0, 0, -128, -128, 1, 0, 0, 0, 0, 0));
      // half width truncates to zero: every row undrawn
      eye_plan.push_back(mk_eye(500, 300, 10, -10, 20, 1, 0, 0, 0, 0));
      // rounding equal to half width: top row undrawn
      eye_plan.push_back(mk_eye(700, 700, -5, 5, 16, 127, 0, 0, 63, 63));
      eye_plan.push_back(mk_eye(1000, 1000, 0, 0, 32, 64, 0, 0, 10, 20));
      // just over the height cap, tiny negative tilts
      eye_plan.push_back(mk_eye(100, 2000, -1, 1, 33, 90, -1, -1, 7, 30));
      eye_plan.push_back(mk_eye(2047, 0, -128, 127, 5, 126, 0, 0, 1, 63));
      eye_plan.push_back(mk_eye(300, 300, 0, 0, 63, 100, -256, -256, 40, 8));
      // odd total height
      eye_plan.push_back(mk_eye(1200, 800, 3, 3, 31, 77, 255, 255, 12, 12));
      // empty eye with every other field busy
      eye_plan.push_back(mk_eye(55, 66, 77, -77, 0, 127, -256, 255, 63, 63));
      eye_plan.push_back(mk_eye(9, 9, 0, 0, 3, 3, 0, 0, 1, 1));
      eye_plan.push_back(mk_eye(640, 480, 0, 0, 2, 2, 0, 0, 0, 0));
      send_plan(1'b0);
      drain();

      // random, fill_color at all ones
      write_fill(16'hFFFF);
      plan_random(100);
      send_plan(1'b0);
      drain();

      // random with the long span-side hold-off; input offered back to back
      write_fill(16'($urandom_range(1, 16'hFFFE)));
      squeeze_req = 1'b1;
      plan_random(90);
      send_plan(1'b1);
      drain();

      write_fill(16'($urandom_range(0, 16'hFFFF)));
      plan_random(80);
      send_plan(1'b0);
      drain();

      repeat (TAIL_CYCLES) @(negedge clock);

      $display("Ran %0d eye words (%0d empty) through %0d fill_color writes,",
               eyes_seen, empty_seen, color_writes);
      $display("checking %0d span words, %0d drawn, with one long output hold-off.",
               spans_seen, drawn_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches, %0d span words never seen", fail_count, pending);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/resr_pkg.sv
hdl/resr_front.sv
hdl/resr_queue.sv
hdl/resr_back.sv
hdl/rounded_eye_span_rasterizer_top.sv
bench/resr_span_checker.sv
bench/tb_top.sv
